// ===== sv/bssd_pkg.sv =====
// ----------------------------------------------------------------------------
// bssd_pkg
// Shared constants for the best-sink subset dynamic program.
// ----------------------------------------------------------------------------
package bssd_pkg;

  // score format: signed Q31.16 in 48 bits
  localparam int SCORE_W = 48;
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // variable count register
  localparam int VAR_COUNT_W = 5;
  localparam logic [VAR_COUNT_W-1:0] VAR_COUNT_RESET = 5'd16;

  // result queue depth, a power of two
  localparam int OQ_DEPTH = 8;

endpackage

// ===== sv/bssd_ram.sv =====
// ----------------------------------------------------------------------------
// bssd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bssd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/best_sink_subset_dp_unit.sv =====
// ----------------------------------------------------------------------------
// best_sink_subset_dp_unit
// Walks variable subsets in ascending order, adds each sink's parent score to
// the stored score of the subset without that sink and keeps the best sink.
// ----------------------------------------------------------------------------
// an item's results are registered in the stage, then queued for the output
// throughput: one item per cycle unless in_stall; the store read issued at
//   accept is forwarded if the staged item writes the same subset at that edge
// the input stalls unless the 8-entry result queue has room for two results
//   of the staged item and two of a new one
// reset: walk restarts at the empty subset, var_count returns to 16, store kept
module best_sink_subset_dp_unit
  import bssd_pkg::*;
#(
  parameter int MAX_VARS = 16,
  localparam int SINK_W = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  // item input
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [SCORE_W-1:0] parent_score,
  // result output
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [MAX_VARS-1:0]       subset,
  output logic                      sink_found,
  output logic [SINK_W-1:0]         chosen_sink,
  output logic signed [SCORE_W-1:0] net_score,
  output logic                      last_subset,
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [VAR_COUNT_W-1:0]    var_count
);

  localparam int QPTR_W = $clog2(OQ_DEPTH);
  localparam int QCNT_W = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [MAX_VARS-1:0]       subset;
    logic                      found;
    logic [SINK_W-1:0]         sink;
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } result_t;

  function automatic logic [SINK_W-1:0] lowest_bit(input logic [MAX_VARS-1:0] v);
    logic [SINK_W-1:0] idx;
    idx = '0;
    for (int i = MAX_VARS - 1; i >= 0; i--) begin
      if (v[i]) idx = SINK_W'(i);
    end
    return idx;
  endfunction

  // configuration and walk position
  logic [VAR_COUNT_W-1:0] n_vars;
  logic [MAX_VARS-1:0]    cur_subset;
  logic [SINK_W-1:0]      cur_sink;

  // stage registers
  logic                      st_valid;
  logic signed [SCORE_W-1:0] st_score;
  logic [SINK_W-1:0]         st_sink;
  logic [MAX_VARS-1:0]       st_subset;
  logic                      st_empty;
  logic                      st_last_member;
  logic                      st_full;
  logic                      st_base_zero;
  logic                      fwd_hit;
  logic signed [SCORE_W-1:0] fwd_data;

  // running best of the subset in progress
  logic signed [SCORE_W-1:0] run_score;
  logic [SINK_W-1:0]         run_sink;
  logic                      run_found;

  // result queue
  result_t             queue [OQ_DEPTH];
  logic [QPTR_W-1:0]   q_head;
  logic [QPTR_W-1:0]   q_tail;
  logic [QCNT_W-1:0]   q_count;

  logic in_accept;
  logic cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign in_accept = in_valid & ~in_stall;

  // effective variable count and full-set mask
  logic [VAR_COUNT_W-1:0] n_eff;
  logic [MAX_VARS-1:0]    full_mask;

  always_comb begin
    if (n_vars == '0) begin
      n_eff = VAR_COUNT_W'(1);
    end else if (n_vars > VAR_COUNT_W'(MAX_VARS)) begin
      n_eff = VAR_COUNT_W'(MAX_VARS);
    end else begin
      n_eff = n_vars;
    end
    for (int i = 0; i < MAX_VARS; i++) begin
      full_mask[i] = (VAR_COUNT_W'(i) < n_eff);
    end
  end

  // front end: sink, base subset and next walk position
  logic                      fe_empty;
  logic [MAX_VARS-1:0]       fe_subset;
  logic [SINK_W-1:0]         fe_sink;
  logic [MAX_VARS-1:0]       fe_base;
  logic [MAX_VARS-1:0]       fe_higher;
  logic [MAX_VARS-1:0]       fe_rest;
  logic                      fe_has_next;
  logic                      fe_at_full;
  logic [MAX_VARS-1:0]       fe_inc;

  always_comb begin
    fe_empty  = (cur_subset == '0);
    fe_subset = fe_empty ? MAX_VARS'(1) : cur_subset;
    fe_sink   = fe_empty ? '0 : cur_sink;
    fe_base   = fe_subset & ~(MAX_VARS'(1) << fe_sink);
    for (int i = 0; i < MAX_VARS; i++) begin
      fe_higher[i] = (SINK_W'(i) > fe_sink);
    end
    fe_rest     = fe_subset & fe_higher;
    fe_has_next = |fe_rest;
    fe_at_full  = (fe_subset == full_mask);
    fe_inc      = fe_subset + MAX_VARS'(1);
  end

  // score store write from the stage
  logic                      wr_en;
  logic signed [SCORE_W-1:0] rd_data;
  logic signed [SCORE_W-1:0] wr_score;

  assign wr_en = st_valid & st_last_member;

  bssd_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (2 ** MAX_VARS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (st_subset),
    .wr_data (wr_score),
    .rd_en   (in_accept),
    .rd_addr (fe_base),
    .rd_data (rd_data)
  );

  // walk position update
  always_ff @(posedge clk) begin
    if (rst) begin
      n_vars     <= VAR_COUNT_RESET;
      cur_subset <= '0;
      cur_sink   <= '0;
    end else if (cfg_we) begin
      n_vars     <= var_count;
      cur_subset <= '0;
      cur_sink   <= '0;
    end else if (in_accept) begin
      if (fe_has_next) begin
        cur_subset <= fe_subset;
        cur_sink   <= lowest_bit(fe_rest);
      end else if (fe_at_full) begin
        cur_subset <= '0;
        cur_sink   <= '0;
      end else begin
        cur_subset <= fe_inc;
        cur_sink   <= lowest_bit(fe_inc);
      end
    end
  end

  // stage capture
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      st_score       <= parent_score;
      st_sink        <= fe_sink;
      st_subset      <= fe_subset;
      st_empty       <= fe_empty;
      st_last_member <= ~fe_has_next;
      st_full        <= fe_at_full;
      st_base_zero   <= (fe_base == '0);
      fwd_hit        <= wr_en && (st_subset == fe_base);
      fwd_data       <= wr_score;
    end
  end

  // add with saturation and best-sink compare
  logic signed [SCORE_W-1:0] st_operand;
  logic signed [SCORE_W:0]   st_wide;
  logic signed [SCORE_W-1:0] st_sum;
  logic                      st_take;
  logic [SINK_W-1:0]         new_sink;

  always_comb begin
    if (st_base_zero) begin
      st_operand = '0;
    end else if (fwd_hit) begin
      st_operand = fwd_data;
    end else begin
      st_operand = rd_data;
    end
    st_wide = {st_operand[SCORE_W-1], st_operand} + {st_score[SCORE_W-1], st_score};
    if (st_wide[SCORE_W] != st_wide[SCORE_W-1]) begin
      st_sum = st_wide[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end else begin
      st_sum = st_wide[SCORE_W-1:0];
    end
    st_take  = ~run_found || (run_score < st_sum);
    wr_score = st_take ? st_sum : run_score;
    new_sink = st_take ? st_sink : run_sink;
  end

  // running best, cleared at the end of each subset
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      run_score <= '0;
      run_sink  <= '0;
      run_found <= 1'b0;
    end else if (st_valid) begin
      if (st_last_member) begin
        run_score <= '0;
        run_sink  <= '0;
        run_found <= 1'b0;
      end else begin
        run_score <= wr_score;
        run_sink  <= new_sink;
        run_found <= 1'b1;
      end
    end
  end

  // result queue push and pop
  logic    push_empty;
  logic    push_main;
  logic    q_pop;
  result_t empty_rec;
  result_t main_rec;
  logic [QPTR_W-1:0] main_slot;

  always_comb begin
    push_empty = st_valid & st_empty;
    push_main  = st_valid & st_last_member;
    q_pop      = out_valid & ~out_stall;
    main_slot  = q_tail + QPTR_W'(push_empty);

    empty_rec.subset = '0;
    empty_rec.found  = 1'b0;
    empty_rec.sink   = '0;
    empty_rec.score  = '0;
    empty_rec.last   = 1'b0;

    main_rec.subset = st_subset;
    main_rec.found  = 1'b1;
    main_rec.sink   = new_sink;
    main_rec.score  = wr_score;
    main_rec.last   = st_full;
  end

  always_ff @(posedge clk) begin
    if (push_empty) begin
      queue[q_tail] <= empty_rec;
    end
    if (push_main) begin
      queue[main_slot] <= main_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
    end else begin
      q_tail  <= q_tail + QPTR_W'(push_empty) + QPTR_W'(push_main);
      q_head  <= q_head + QPTR_W'(q_pop);
      q_count <= q_count + QCNT_W'(push_empty) + QCNT_W'(push_main) - QCNT_W'(q_pop);
    end
  end

  // keep room for two results of the staged item and two of a new one
  logic [QCNT_W:0] q_reserved;

  always_comb begin
    q_reserved = {1'b0, q_count} + (st_valid ? (QCNT_W + 1)'(2) : '0);
    in_stall   = (q_reserved > (QCNT_W + 1)'(OQ_DEPTH - 2));
  end

  // output from the queue head
  result_t head_rec;

  always_comb begin
    head_rec    = queue[q_head];
    out_valid   = (q_count != '0);
    subset      = head_rec.subset;
    sink_found  = head_rec.found;
    chosen_sink = head_rec.sink;
    net_score   = head_rec.score;
    last_subset = head_rec.last;
  end

endmodule

// ===== dv/best_sink_dp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// best_sink_dp_checker
// Watches the item, result and register channels of the best-sink unit. It
// keeps its own copy of the subset walk and score store, predicts the results
// of every accepted item and compares them, field by field and in order, with
// the results that the unit hands out.
// ----------------------------------------------------------------------------
module best_sink_dp_checker
  import bssd_pkg::*;
#(
  parameter int MAX_VARS = 16,
  localparam int SINK_W = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [SCORE_W-1:0] parent_score,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [MAX_VARS-1:0]       subset,
  input  logic                      sink_found,
  input  logic [SINK_W-1:0]         chosen_sink,
  input  logic signed [SCORE_W-1:0] net_score,
  input  logic                      last_subset,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [VAR_COUNT_W-1:0]    var_count,
  output int                        fail_count,
  output int                        pending,
  output int                        results_seen
);

  localparam int STORE_DEPTH = 1 << MAX_VARS;
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [MAX_VARS-1:0]       subset;
    logic                      found;
    logic [SINK_W-1:0]         sink;
    logic signed [SCORE_W-1:0] score;
    logic                      last;
  } subset_result_t;

  // model state
  logic signed [SCORE_W-1:0] subset_score_mem [STORE_DEPTH];
  int                        cur_set;
  int                        cur_sink;
  int                        run_sink;
  logic signed [SCORE_W-1:0] run_score;
  bit                        run_found;
  logic [VAR_COUNT_W-1:0]    vc_reg;
  subset_result_t            expected_results [$];

  // register value as the walk uses it
  function automatic int active_vars(input logic [VAR_COUNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_VARS) return MAX_VARS;
    return int'(v);
  endfunction

  function automatic int lowest_member(input int set);
    for (int t = 0; t < MAX_VARS; t++)
      if (set[t]) return t;
    return 0;
  endfunction

  // 48-bit add clamped to the signed range
  function automatic logic signed [SCORE_W-1:0] sat_add(
    input logic signed [SCORE_W-1:0] a,
    input logic signed [SCORE_W-1:0] b
  );
    logic [SCORE_W:0] wide;
    wide = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
    if (wide[SCORE_W] != wide[SCORE_W-1])
      return wide[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    return wide[SCORE_W-1:0];
  endfunction

  task automatic clear_running();
    run_score = '0;
    run_sink = 0;
    run_found = 1'b0;
  endtask

  task automatic queue_result(input int set, input bit found, input int sink,
                              input logic signed [SCORE_W-1:0] score, input bit last);
    subset_result_t r;
    r.subset = MAX_VARS'(set);
    r.found = found;
    r.sink = SINK_W'(sink);
    r.score = score;
    r.last = last;
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP)
      $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // one item: score of the next member sink of the current subset
  task automatic take_item(input logic signed [SCORE_W-1:0] ps);
    int n;
    int full;
    int sink;
    int base;
    bit more;
    logic signed [SCORE_W-1:0] cand;
    n = active_vars(vc_reg);
    full = (1 << n) - 1;
    // empty subset result rides on the first item of a pass
    if (cur_set == 0 || cur_set > full) begin
      subset_score_mem[0] = '0;
      queue_result(0, 1'b0, 0, '0, 1'b0);
      cur_set = 1;
      cur_sink = 0;
      clear_running();
    end
    sink = cur_sink;
    if (sink >= n || !cur_set[sink])
      sink = lowest_member(cur_set);
    base = cur_set & ~(1 << sink);
    cand = sat_add(subset_score_mem[base], ps);
    // strict compare keeps the earlier sink on a tie
    if (!run_found || run_score < cand) begin
      run_score = cand;
      run_sink = sink;
      run_found = 1'b1;
    end
    more = 1'b0;
    for (int t = sink + 1; t < n; t++)
      if (!more && cur_set[t]) begin
        cur_sink = t;
        more = 1'b1;
      end
    // last member: store the subset score and move on
    if (!more) begin
      subset_score_mem[cur_set] = run_score;
      queue_result(cur_set, 1'b1, run_sink, run_score, cur_set == full);
      if (cur_set == full) begin
        cur_set = 0;
        cur_sink = 0;
      end else begin
        cur_set++;
        cur_sink = lowest_member(cur_set);
      end
      clear_running();
    end
  endtask

  task automatic check_result();
    subset_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result for subset %0h with nothing expected", subset));
      return;
    end
    want = expected_results.pop_front();
    if (subset !== want.subset)
      report_mismatch($sformatf("subset: got %0h, want %0h", subset, want.subset));
    if (sink_found !== want.found)
      report_mismatch($sformatf("subset %0h sink_found: got %0b, want %0b",
                                want.subset, sink_found, want.found));
    if (chosen_sink !== want.sink)
      report_mismatch($sformatf("subset %0h chosen_sink: got %0d, want %0d",
                                want.subset, chosen_sink, want.sink));
    if (net_score !== want.score)
      report_mismatch($sformatf("subset %0h net_score: got %0d, want %0d",
                                want.subset, net_score, want.score));
    if (last_subset !== want.last)
      report_mismatch($sformatf("subset %0h last_subset: got %0b, want %0b",
                                want.subset, last_subset, want.last));
  endtask

  // channel monitor
  always @(posedge clk) begin
    if (rst) begin
      cur_set = 0;
      cur_sink = 0;
      clear_running();
      vc_reg = VAR_COUNT_RESET;
      expected_results.delete();
    end else begin
      // register write restarts the walk, stored scores stay
      if (cfg_valid && cfg_ready) begin
        vc_reg = var_count;
        cur_set = 0;
        cur_sink = 0;
        clear_running();
      end
      if (in_valid && !in_stall)
        take_item(parent_score);
      if (out_valid && !out_stall)
        check_result();
    end
    pending <= expected_results.size();
  end

endmodule

// ===== dv/tb_best_sink_subset_dp_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_best_sink_subset_dp_unit
// Drives parent scores into the best-sink subset unit in bursts, stalls the
// result side on its own pattern and changes var_count between phases. A
// directed opening hits score extremes, saturation, ties, the empty set and
// the pass wrap; random phases then run whole and broken passes.
// ----------------------------------------------------------------------------
module tb_best_sink_subset_dp_unit;
  import bssd_pkg::*;

  localparam int MAX_VARS = 16;
  localparam int SINK_W = $clog2(MAX_VARS);
  localparam int TOTAL_ITEMS = 450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES = 300;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [SCORE_W-1:0] parent_score;
  logic                      out_valid;
  logic                      out_stall;
  logic [MAX_VARS-1:0]       subset;
  logic                      sink_found;
  logic [SINK_W-1:0]         chosen_sink;
  logic signed [SCORE_W-1:0] net_score;
  logic                      last_subset;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [VAR_COUNT_W-1:0]    var_count;

  int fail_count;
  int pending;
  int results_seen;
  int items_sent;
  int cfg_writes;
  int burst_left;
  int cycles;
  bit hold_req;

  best_sink_subset_dp_unit #(.MAX_VARS(MAX_VARS)) uut (.*);

  best_sink_dp_checker #(.MAX_VARS(MAX_VARS)) dp_check (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("Test completed with failures");
    $finish;
  end

  // result side stall pattern, with one long hold-off on request
  initial begin
    int stretch;
    int pct;
    out_stall <= 1'b0;
    stretch = 0;
    pct = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(10, 120);
          case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 25;
            2: pct = 50;
            default: pct = 85;
          endcase
        end
        stretch--;
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  function automatic int items_per_pass(input int n);
    return n << (n - 1);
  endfunction

  // mix of full range, extremes, small tie values and near-saturation values
  function automatic logic signed [SCORE_W-1:0] random_score();
    int r;
    int small_v;
    logic [63:0] raw;
    logic signed [SCORE_W-1:0] val;
    r = $urandom_range(0, 99);
    raw = {$urandom, $urandom};
    if (r < 40) begin
      val = raw[SCORE_W-1:0];
    end else if (r < 55) begin
      case ($urandom_range(0, 5))
        0: val = SCORE_MAX;
        1: val = SCORE_MIN;
        2: val = '0;
        3: val = '1;
        4: val = SCORE_MAX - SCORE_W'(1);
        default: val = SCORE_MIN + SCORE_W'(1);
      endcase
    end else if (r < 70) begin
      small_v = int'($urandom_range(0, 6)) - 3;
      val = SCORE_W'(small_v);
    end else if (r < 85) begin
      val = SCORE_MAX - SCORE_W'(raw[15:0]);
    end else begin
      val = SCORE_MIN + SCORE_W'(raw[15:0]);
    end
    return val;
  endfunction

  // mostly small walks, now and then the clamped values and large walks
  function automatic logic [VAR_COUNT_W-1:0] pick_var_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return VAR_COUNT_W'($urandom_range(1, 4));
    if (r < 80) return VAR_COUNT_W'(5);
    if (r < 88) return VAR_COUNT_W'($urandom_range(0, 1));
    return VAR_COUNT_W'($urandom_range(6, 31));
  endfunction

  // one item, then either stay in the burst or leave a gap
  task automatic send_score(input logic signed [SCORE_W-1:0] value);
    int gap;
    in_valid <= 1'b1;
    parent_score <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 15);
    end
  endtask

  // stop sending until every predicted result is in and the pipe is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_var_count(input logic [VAR_COUNT_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    var_count <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // stimulus and verdict
  initial begin
    logic signed [SCORE_W-1:0] dir_scores [$];
    logic [VAR_COUNT_W-1:0] v;
    int n_eff;
    int count;
    int total_items;
    rst <= 1'b1;
    in_valid <= 1'b0;
    parent_score <= '0;
    cfg_valid <= 1'b0;
    var_count <= VAR_COUNT_RESET;
    hold_req = 1'b0;
    items_sent = 0;
    cfg_writes = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset width: saturation both ways, ties and a full-range mix on subsets 1..7
    dir_scores = '{SCORE_MAX, SCORE_MAX, SCORE_MAX, SCORE_MAX, SCORE_MIN, SCORE_MIN,
                   SCORE_MIN, '1, '0, SCORE_W'(1), '1, SCORE_W'(1)};
    foreach (dir_scores[i]) send_score(dir_scores[i]);

    // zero is taken as one variable: every item gives the empty set and the full set
    write_var_count(VAR_COUNT_W'(0));
    send_score(SCORE_W'(5));
    send_score(SCORE_W'(-5));

    // two variables: tie on the full set, then the wrap back to the empty set
    write_var_count(VAR_COUNT_W'(2));
    repeat (4) send_score(SCORE_W'(7));
    send_score(SCORE_W'(3));

    // above the maximum is clamped, walk left in the middle of a subset
    write_var_count(VAR_COUNT_W'(31));
    send_score('0);
    send_score(SCORE_MIN);
    send_score(SCORE_MAX);

    total_items = TOTAL_ITEMS;

    // long result hold-off while items keep coming, so the input backs up
    write_var_count(VAR_COUNT_W'(3));
    hold_req = 1'b1;
    burst_left = 40;
    repeat (3 * items_per_pass(3)) send_score(random_score());
    // sender pauses until all results are in, no register write
    drain_results();
    repeat (items_per_pass(3)) send_score(random_score());

    // random phases: whole passes, sometimes broken off inside a subset
    while (items_sent < total_items) begin
      v = pick_var_count();
      write_var_count(v);
      n_eff = (v == 0) ? 1 : (v > MAX_VARS) ? MAX_VARS : int'(v);
      if (n_eff <= 4)
        count = $urandom_range(1, 3) * items_per_pass(n_eff);
      else if (n_eff == 5)
        count = items_per_pass(n_eff);
      else
        count = $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0)
        count += $urandom_range(1, n_eff);
      if (count > total_items - items_sent)
        count = total_items - items_sent;
      repeat (count) send_score(random_score());
    end
    drain_results();

    $display("run covered %0d items, %0d results and %0d var_count writes",
             items_sent, results_seen, cfg_writes);
    $display("incl. clamped counts, saturation, ties, pass wrap, broken passes, %0d-cycle hold",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
